FILE: hw/rtl/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Types and byte-class constants shared by the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

	localparam int unsigned CpWidth   = 21;
	localparam int unsigned LenWidth  = 3;
	localparam int unsigned DropWidth = 8;

	// leader and continuation byte classes (mask, match)
	localparam logic [7:0] AsciiMask = 8'h80;
	localparam logic [7:0] AsciiVal  = 8'h00;
	localparam logic [7:0] Lead2Mask = 8'he0;
	localparam logic [7:0] Lead2Val  = 8'hc0;
	localparam logic [7:0] Lead3Mask = 8'hf0;
	localparam logic [7:0] Lead3Val  = 8'he0;
	localparam logic [7:0] Lead4Mask = 8'hf8;
	localparam logic [7:0] Lead4Val  = 8'hf0;
	localparam logic [7:0] ContMask  = 8'hc0;
	localparam logic [7:0] ContVal   = 8'h80;

	localparam logic [DropWidth-1:0] DropMax = '1;

	typedef struct packed {
		logic [1:0]           needed;
		logic [LenWidth-1:0]  total;
		logic [CpWidth-1:0]   acc;
		logic [DropWidth-1:0] drops;
	} dec_state_t;

	typedef struct packed {
		logic                 emit;
		logic [CpWidth-1:0]   codepoint;
		logic [LenWidth-1:0]  seq_length;
		logic [DropWidth-1:0] dropped_before;
	} dec_result_t;

endpackage

FILE: hw/rtl/u8d_step.sv
// ----------------------------------------------------------------------------
// u8d_step
// One-byte decode step: next sequence state and the optional result.
// ----------------------------------------------------------------------------
module u8d_step import u8d_pkg::*; (
	input  logic [7:0] data_byte,
	input  dec_state_t cur,
	output dec_state_t nxt,
	output dec_result_t res
);

	function automatic logic [DropWidth-1:0] sat_add(input logic [DropWidth-1:0] a,
		input logic [LenWidth-1:0] b);
		logic [DropWidth:0] s;
		s = {1'b0, a} + {{(DropWidth+1-LenWidth){1'b0}}, b};
		return s[DropWidth] ? DropMax : s[DropWidth-1:0];
	endfunction

	logic                 pending;
	logic                 is_cont;
	logic [CpWidth-1:0]   acc_shift;
	logic [1:0]           needed_dec;
	logic [LenWidth-1:0]  bad_cnt;
	logic [DropWidth-1:0] base_drops;

	assign pending    = (cur.needed != 2'd0);
	assign is_cont    = ((data_byte & ContMask) == ContVal);
	assign acc_shift  = {cur.acc[CpWidth-7:0], data_byte[5:0]};
	assign needed_dec = cur.needed - 2'd1;
	// bytes already taken for the pending sequence
	assign bad_cnt    = pending ? (cur.total - {1'b0, cur.needed}) : '0;
	assign base_drops = sat_add(cur.drops, bad_cnt);

	always_comb begin
		nxt = cur;
		res.emit           = 1'b0;
		res.codepoint      = acc_shift;
		res.seq_length     = cur.total;
		res.dropped_before = cur.drops;
		if (pending && is_cont) begin
			nxt.acc    = acc_shift;
			nxt.needed = needed_dec;
			if (needed_dec == 2'd0) begin
				res.emit  = 1'b1;
				nxt.total = '0;
				nxt.acc   = '0;
				nxt.drops = '0;
			end
		end else begin
			// idle or bad continuation: byte is looked at as a leader
			nxt.needed = 2'd0;
			nxt.total  = '0;
			nxt.acc    = '0;
			nxt.drops  = base_drops;
			res.codepoint      = {{(CpWidth-8){1'b0}}, data_byte};
			res.seq_length     = LenWidth'(1);
			res.dropped_before = base_drops;
			priority if ((data_byte & AsciiMask) == AsciiVal) begin
				res.emit  = 1'b1;
				nxt.drops = '0;
			end else if ((data_byte & Lead2Mask) == Lead2Val) begin
				nxt.acc    = {{(CpWidth-5){1'b0}}, data_byte[4:0]};
				nxt.needed = 2'd1;
				nxt.total  = LenWidth'(2);
			end else if ((data_byte & Lead3Mask) == Lead3Val) begin
				nxt.acc    = {{(CpWidth-4){1'b0}}, data_byte[3:0]};
				nxt.needed = 2'd2;
				nxt.total  = LenWidth'(3);
			end else if ((data_byte & Lead4Mask) == Lead4Val) begin
				nxt.acc    = {{(CpWidth-3){1'b0}}, data_byte[2:0]};
				nxt.needed = 2'd3;
				nxt.total  = LenWidth'(4);
			end else begin
				nxt.drops = sat_add(base_drops, LenWidth'(1));
			end
		end
	end

endmodule

FILE: hw/rtl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 decoder, one byte in, zero or one code point out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries raw stream bytes, one per transfer. m_* carries decoded
//   code points with their sequence length and the count of bytes dropped
//   since the previous result (saturating at 255).
//   A byte is held in an input register, decoded by one combinational step
//   and its result lands in the output register behind m_tvalid and m_tdata.
//   Throughput is one byte per cycle, limited only by the output register:
//   a byte that completes a sequence waits in the input register while the
//   previous result is not yet taken, and s_tready stays low until the
//   output register frees up. Bytes that only extend a sequence or are
//   dropped pass through even while the output is stalled.
//   Reset clears the pending sequence, the drop count and both valid flags.
//   An incomplete trailing sequence stays pending and produces nothing.
// ----------------------------------------------------------------------------
module utf8_stream_decoder import u8d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // codepoint[20:0], seq_length[23:21], dropped_before[31:24]
);

	logic        byte_valid_s1;
	logic [7:0]  byte_s1;
	dec_state_t  state_q;
	dec_state_t  state_next;
	dec_result_t step_res;
	logic        out_free;
	logic        advance;
	logic [CpWidth-1:0]   codepoint_q;
	logic [LenWidth-1:0]  seq_length_q;
	logic [DropWidth-1:0] dropped_q;

	u8d_step u_step (
		.data_byte(byte_s1),
		.cur      (state_q),
		.nxt      (state_next),
		.res      (step_res)
	);

	assign out_free = !m_tvalid || m_tready;
	assign advance  = byte_valid_s1 && (!step_res.emit || out_free);
	assign s_tready = !byte_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
			state_q       <= '0;
			m_tvalid      <= 1'b0;
		end else begin
			if (s_tready) begin
				byte_valid_s1 <= s_tvalid;
			end
			if (advance) begin
				state_q <= state_next;
			end
			if (advance && step_res.emit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
		if (advance && step_res.emit) begin
			codepoint_q  <= step_res.codepoint;
			seq_length_q <= step_res.seq_length;
			dropped_q    <= step_res.dropped_before;
		end
	end

	assign m_tdata = {dropped_q, seq_length_q, codepoint_q};

	// a pending sequence always has its leader counted in the total
	a_pending_total: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.needed != 2'd0) |-> (state_q.total > {1'b0, state_q.needed}))
		else $error("pending sequence total inconsistent");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.needed == 2'd0) |-> (state_q.total == '0 && state_q.acc == '0))
		else $error("idle state not cleared");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (seq_length_q != '0 && seq_length_q <= LenWidth'(4)))
		else $error("result length out of range");

	a_ascii_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && seq_length_q == LenWidth'(1)) |-> (codepoint_q[CpWidth-1:7] == '0))
		else $error("single-byte result wider than seven bits");

	a_drops_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_res.emit) |=> (state_q.drops == '0))
		else $error("drop count not cleared after result");

endmodule
